@@ rtl/ddoi_pkg.sv @@
// ddoi_pkg: shared types, constants and tables for the odometry integrator.
// Used by ddoi_ctrl, ddoi_datapath and the top level. No dependencies.
`default_nettype none
package ddoi_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CNT_W            = 6;
   localparam int SQRT_STEPS       = 32;

   localparam logic [15:0] HWR_RESET = 16'd4358;
   localparam logic [15:0] ROT_RESET = 16'd14289;
   localparam logic [23:0] TS_RESET  = 24'd83886;

   // 1/(4*pi) turns per radian, Q0.32; CORDIC gain compensation, Q2.30
   localparam logic signed [32:0] INV_FOUR_PI = 33'sd341782638;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [1:0] {
      CSR_HWR = 2'd0,
      CSR_ROT = 2'd1,
      CSR_TS  = 2'd2
   } csr_idx_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MV, ST_MW, ST_MS, ST_MP, ST_PW, ST_MD, ST_DW, ST_CI1, ST_C1,
      ST_MX, ST_MY, ST_CI2, ST_C2, ST_MVX, ST_MVY, ST_ERR, ST_MEX, ST_MEY,
      ST_SUM, ST_SQ, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_V, MUL_W, MUL_S, MUL_P, MUL_D, MUL_X, MUL_Y, MUL_VX, MUL_VY,
      MUL_EX, MUL_EY
   } mul_sel_type;

   typedef enum logic [3:0] {
      WB_NONE, WB_V, WB_W, WB_S, WB_P, WB_D, WB_X, WB_Y, WB_VX, WB_VY, WB_SQX
   } wb_sel_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      wb_sel_type  wb_sel;
      logic        cordic_init;
      logic        cordic_head;
      logic        cordic_step;
      logic [4:0]  step;
      logic        err_calc;
      logic        sum_load;
      logic        sqrt_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/diff_drive_odometry_integrator.sv @@
// Top level of the differential-drive odometry integrator.
// Depends on ddoi_pkg, ddoi_ctrl and ddoi_datapath.
//
//  channel  dir  handshake               payload
//  req_     in   req_tvalid/req_tready   req_tdata[111:0]
//  rsp_     out  rsp_tvalid/rsp_tready   rsp_tdata[255:0]
//  csr_     in   csr_valid/csr_ready     csr_index[1:0], csr_data[23:0]
//
// From accept to result a request goes through two CORDIC passes of
// CORDIC_STEPS iterations, 32 square-root steps and eleven products through
// one shared multiplier.
// One request at a time; the next is taken once the result sits in the output
// register, even while rsp_tready is low. Reset is synchronous and clears the
// position and the register file to their defaults. csr_ready is always high.
`default_nettype none
module diff_drive_odometry_integrator #(
   parameter int CORDIC_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // wheel_speed_left[15:0], wheel_speed_right[31:16], heading[47:32],
   // ref_x[79:48], ref_y[111:80]
   input  wire  [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96], turn_rate[159:128],
   // err_x[191:160], err_y[223:192], err_norm[255:224]
   output logic [255:0] rsp_tdata,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [1:0]   csr_index,
   input  wire  [23:0]  csr_data
);

   ddoi_pkg::cmd_type    cmd;
   ddoi_pkg::status_type status;

   assign csr_ready = 1'b1;

   ddoi_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ddoi_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire

@@ rtl/ddoi_ctrl.sv @@
// ddoi_ctrl: sequencer for the odometry integrator datapath.
// Depends on ddoi_pkg.
`default_nettype none
module ddoi_ctrl #(
   parameter int CORDIC_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  ddoi_pkg::status_type status,
   output ddoi_pkg::cmd_type    cmd
);

   localparam logic [ddoi_pkg::CNT_W-1:0] CORDIC_LAST = ddoi_pkg::CNT_W'(CORDIC_STEPS - 1);
   localparam logic [ddoi_pkg::CNT_W-1:0] SQRT_LAST   =
      ddoi_pkg::CNT_W'(ddoi_pkg::SQRT_STEPS - 1);

   ddoi_pkg::state_type state_ff, state_in;
   logic [ddoi_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic cordic_done, sqrt_done;

   assign cordic_done = (cnt_ff == CORDIC_LAST);
   assign sqrt_done   = (cnt_ff == SQRT_LAST);
   assign req_tready  = (state_ff == ddoi_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddoi_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      unique case (state_ff)
         ddoi_pkg::ST_IDLE: if (req_tvalid) state_in = ddoi_pkg::ST_MV;
         ddoi_pkg::ST_MV:   state_in = ddoi_pkg::ST_MW;
         ddoi_pkg::ST_MW:   state_in = ddoi_pkg::ST_MS;
         ddoi_pkg::ST_MS:   state_in = ddoi_pkg::ST_MP;
         ddoi_pkg::ST_MP:   state_in = ddoi_pkg::ST_PW;
         ddoi_pkg::ST_PW:   state_in = ddoi_pkg::ST_MD;
         ddoi_pkg::ST_MD:   state_in = ddoi_pkg::ST_DW;
         ddoi_pkg::ST_DW:   state_in = ddoi_pkg::ST_CI1;
         ddoi_pkg::ST_CI1:  state_in = ddoi_pkg::ST_C1;
         ddoi_pkg::ST_C1: begin
            if (cordic_done) state_in = ddoi_pkg::ST_MX;
            else cnt_in = cnt_ff + 1'b1;
         end
         ddoi_pkg::ST_MX:   state_in = ddoi_pkg::ST_MY;
         ddoi_pkg::ST_MY:   state_in = ddoi_pkg::ST_CI2;
         ddoi_pkg::ST_CI2:  state_in = ddoi_pkg::ST_C2;
         ddoi_pkg::ST_C2: begin
            if (cordic_done) state_in = ddoi_pkg::ST_MVX;
            else cnt_in = cnt_ff + 1'b1;
         end
         ddoi_pkg::ST_MVX:  state_in = ddoi_pkg::ST_MVY;
         ddoi_pkg::ST_MVY:  state_in = ddoi_pkg::ST_ERR;
         ddoi_pkg::ST_ERR:  state_in = ddoi_pkg::ST_MEX;
         ddoi_pkg::ST_MEX:  state_in = ddoi_pkg::ST_MEY;
         ddoi_pkg::ST_MEY:  state_in = ddoi_pkg::ST_SUM;
         ddoi_pkg::ST_SUM:  state_in = ddoi_pkg::ST_SQ;
         ddoi_pkg::ST_SQ: begin
            if (sqrt_done) state_in = ddoi_pkg::ST_OUT;
            else cnt_in = cnt_ff + 1'b1;
         end
         ddoi_pkg::ST_OUT:  if (status.out_free) state_in = ddoi_pkg::ST_IDLE;
         default:           state_in = ddoi_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd      = '0;
      cmd.step = cnt_ff[4:0];
      unique case (state_ff)
         ddoi_pkg::ST_IDLE: cmd.load_in = req_tvalid;
         ddoi_pkg::ST_MV:   cmd.mul_sel = ddoi_pkg::MUL_V;
         ddoi_pkg::ST_MW: begin
            cmd.mul_sel = ddoi_pkg::MUL_W;
            cmd.wb_sel  = ddoi_pkg::WB_V;
         end
         ddoi_pkg::ST_MS: begin
            cmd.mul_sel = ddoi_pkg::MUL_S;
            cmd.wb_sel  = ddoi_pkg::WB_W;
         end
         ddoi_pkg::ST_MP: begin
            cmd.mul_sel = ddoi_pkg::MUL_P;
            cmd.wb_sel  = ddoi_pkg::WB_S;
         end
         ddoi_pkg::ST_PW:   cmd.wb_sel = ddoi_pkg::WB_P;
         ddoi_pkg::ST_MD:   cmd.mul_sel = ddoi_pkg::MUL_D;
         ddoi_pkg::ST_DW:   cmd.wb_sel = ddoi_pkg::WB_D;
         ddoi_pkg::ST_CI1:  cmd.cordic_init = 1'b1;
         ddoi_pkg::ST_C1:   cmd.cordic_step = 1'b1;
         ddoi_pkg::ST_MX:   cmd.mul_sel = ddoi_pkg::MUL_X;
         ddoi_pkg::ST_MY: begin
            cmd.mul_sel = ddoi_pkg::MUL_Y;
            cmd.wb_sel  = ddoi_pkg::WB_X;
         end
         ddoi_pkg::ST_CI2: begin
            cmd.wb_sel      = ddoi_pkg::WB_Y;
            cmd.cordic_init = 1'b1;
            cmd.cordic_head = 1'b1;
         end
         ddoi_pkg::ST_C2:   cmd.cordic_step = 1'b1;
         ddoi_pkg::ST_MVX:  cmd.mul_sel = ddoi_pkg::MUL_VX;
         ddoi_pkg::ST_MVY: begin
            cmd.mul_sel = ddoi_pkg::MUL_VY;
            cmd.wb_sel  = ddoi_pkg::WB_VX;
         end
         ddoi_pkg::ST_ERR: begin
            cmd.wb_sel   = ddoi_pkg::WB_VY;
            cmd.err_calc = 1'b1;
         end
         ddoi_pkg::ST_MEX:  cmd.mul_sel = ddoi_pkg::MUL_EX;
         ddoi_pkg::ST_MEY: begin
            cmd.mul_sel = ddoi_pkg::MUL_EY;
            cmd.wb_sel  = ddoi_pkg::WB_SQX;
         end
         ddoi_pkg::ST_SUM:  cmd.sum_load = 1'b1;
         ddoi_pkg::ST_SQ:   cmd.sqrt_step = 1'b1;
         ddoi_pkg::ST_OUT:  cmd.out_load = status.out_free;
         default:           cmd.load_in = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/ddoi_datapath.sv @@
// ddoi_datapath: registers, shared multiplier, CORDIC and square-root units.
// Depends on ddoi_pkg; driven by ddoi_ctrl commands.
`default_nettype none
module ddoi_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [111:0]         req_tdata,
   output logic [255:0]         rsp_tdata,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   input  wire                  csr_valid,
   input  wire  [1:0]           csr_index,
   input  wire  [23:0]          csr_data,
   input  ddoi_pkg::cmd_type    cmd,
   output ddoi_pkg::status_type status
);

   logic [15:0] hwr_ff, rot_ff;
   logic [23:0] ts_ff;

   logic signed [16:0] sum_ff, dif_ff;
   logic [15:0]        head_ff, ang_ff;
   logic signed [31:0] rx_ff, ry_ff;
   logic signed [24:0] v_ff, w_ff, p_ff, s_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               flip_ff;
   logic signed [31:0] est_x_ff, est_y_ff, vx_ff, vy_ff;
   logic [31:0]        ex_ff, ey_ff;
   logic [63:0]        sqx_ff, rad_ff;
   logic               ovf_ff;
   logic [34:0]        rem_ff;
   logic [31:0]        root_ff;
   logic signed [65:0] prod_ff;
   logic [255:0]       out_ff;
   logic               valid_ff;

   logic signed [15:0] wl, wr;
   logic signed [32:0] op_a, op_b;
   logic signed [65:0] prod_in;
   logic signed [33:0] cos_v, sin_v, xs, ys, est_sum;
   logic [33:0]        at;
   logic [15:0]        a16, a16f;
   logic               flip_in;
   logic signed [26:0] prod_q30;
   logic signed [32:0] dx, dy;
   logic [34:0]        rem_t, trial;
   logic [31:0]        nrm;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) r = v[31:0];
      else if (v[33]) r = 32'sh8000_0000;
      else r = 32'sh7FFF_FFFF;
      return r;
   endfunction

   assign wl       = req_tdata[15:0];
   assign wr       = req_tdata[31:16];
   assign cos_v    = flip_ff ? -x_ff : x_ff;
   assign sin_v    = flip_ff ? -y_ff : y_ff;
   assign prod_q30 = prod_ff[56:30];

   // shared multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_sel)
         ddoi_pkg::MUL_V:  begin op_a = 33'(sum_ff); op_b = {17'b0, hwr_ff}; end
         ddoi_pkg::MUL_W:  begin op_a = 33'(dif_ff); op_b = {17'b0, rot_ff}; end
         ddoi_pkg::MUL_S:  begin op_a = 33'(v_ff);   op_b = {9'b0, ts_ff}; end
         ddoi_pkg::MUL_P:  begin op_a = 33'(w_ff);   op_b = {9'b0, ts_ff}; end
         ddoi_pkg::MUL_D:  begin op_a = 33'(p_ff);   op_b = ddoi_pkg::INV_FOUR_PI; end
         ddoi_pkg::MUL_X:  begin op_a = 33'(s_ff);   op_b = 33'(cos_v); end
         ddoi_pkg::MUL_Y:  begin op_a = 33'(s_ff);   op_b = 33'(sin_v); end
         ddoi_pkg::MUL_VX: begin op_a = 33'(v_ff);   op_b = 33'(cos_v); end
         ddoi_pkg::MUL_VY: begin op_a = 33'(v_ff);   op_b = 33'(sin_v); end
         ddoi_pkg::MUL_EX: begin op_a = {1'b0, ex_ff}; op_b = {1'b0, ex_ff}; end
         ddoi_pkg::MUL_EY: begin op_a = {1'b0, ey_ff}; op_b = {1'b0, ey_ff}; end
         default:          begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod_in = op_a * op_b;

   // CORDIC: left half-plane angles are turned by half a turn, results negated
   assign a16     = cmd.cordic_head ? head_ff : ang_ff;
   assign flip_in = a16[15] ^ a16[14];
   assign a16f    = flip_in ? (a16 ^ 16'h8000) : a16;
   assign xs      = x_ff >>> cmd.step;
   assign ys      = y_ff >>> cmd.step;
   assign at      = {2'b00, ddoi_pkg::atan_turn(cmd.step)};

   assign est_sum = (cmd.wb_sel == ddoi_pkg::WB_X ? 34'(est_x_ff) : 34'(est_y_ff))
                    + 34'(prod_q30);

   assign dx = 33'(est_x_ff) - 33'(rx_ff);
   assign dy = 33'(est_y_ff) - 33'(ry_ff);

   // one result bit per step, restoring
   assign rem_t = {rem_ff[32:0], rad_ff[63:62]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign nrm   = ovf_ff ? 32'hFFFF_FFFF : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hwr_ff   <= ddoi_pkg::HWR_RESET;
         rot_ff   <= ddoi_pkg::ROT_RESET;
         ts_ff    <= ddoi_pkg::TS_RESET;
         est_x_ff <= '0;
         est_y_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (ddoi_pkg::csr_idx_type'(csr_index))
               ddoi_pkg::CSR_HWR: hwr_ff <= csr_data[15:0];
               ddoi_pkg::CSR_ROT: rot_ff <= csr_data[15:0];
               ddoi_pkg::CSR_TS:  ts_ff  <= csr_data;
               default:           ts_ff  <= ts_ff;
            endcase
         end
         if (cmd.wb_sel == ddoi_pkg::WB_X) est_x_ff <= sat32(est_sum);
         if (cmd.wb_sel == ddoi_pkg::WB_Y) est_y_ff <= sat32(est_sum);
         if (cmd.out_load) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sum_ff  <= 17'(wr) + 17'(wl);
         dif_ff  <= 17'(wr) - 17'(wl);
         head_ff <= req_tdata[47:32];
         rx_ff   <= req_tdata[79:48];
         ry_ff   <= req_tdata[111:80];
      end
      if (cmd.mul_sel != ddoi_pkg::MUL_NONE) prod_ff <= prod_in;
      case (cmd.wb_sel)
         ddoi_pkg::WB_V:   v_ff   <= prod_ff[32:8];
         ddoi_pkg::WB_W:   w_ff   <= prod_ff[32:8];
         ddoi_pkg::WB_S:   s_ff   <= prod_ff[48:24];
         ddoi_pkg::WB_P:   p_ff   <= prod_ff[48:24];
         ddoi_pkg::WB_D:   ang_ff <= head_ff + prod_ff[47:32];
         ddoi_pkg::WB_VX:  vx_ff  <= 32'(prod_q30);
         ddoi_pkg::WB_VY:  vy_ff  <= 32'(prod_q30);
         ddoi_pkg::WB_SQX: sqx_ff <= prod_ff[63:0];
         default:          sqx_ff <= sqx_ff;
      endcase
      if (cmd.cordic_init) begin
         x_ff    <= ddoi_pkg::CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= {{2{a16f[15]}}, a16f, 16'b0};
         flip_ff <= flip_in;
      end else if (cmd.cordic_step) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - signed'(at);
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + signed'(at);
         end
      end
      if (cmd.err_calc) begin
         ex_ff <= dx[32] ? 32'(-dx) : dx[31:0];
         ey_ff <= dy[32] ? 32'(-dy) : dy[31:0];
      end
      if (cmd.sum_load) begin
         {ovf_ff, rad_ff} <= 65'(sqx_ff) + 65'(prod_ff[63:0]);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         if (rem_t >= trial) begin
            rem_ff  <= rem_t - trial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rem_t;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         out_ff <= {nrm, ey_ff, ex_ff, 32'(w_ff), vy_ff, vx_ff, est_y_ff, est_x_ff};
      end
   end

   assign rsp_tdata       = out_ff;
   assign rsp_tvalid      = valid_ff;
   assign status.out_free = !valid_ff || rsp_tready;

endmodule
`default_nettype wire

@@ rtl/ddoi_checker.sv @@
// ddoi_checker: port-level assertions for the odometry integrator.
// Depends on nothing; bound to diff_drive_odometry_integrator.
`default_nettype none
module ddoi_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [255:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared right after accept");

endmodule

bind diff_drive_odometry_integrator ddoi_checker u_ddoi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ tb/diff_drive_odometry_integrator_test.sv @@
// Self-checking testbench for diff_drive_odometry_integrator.
// Drives odometry requests and register writes, predicts each response with a
// local fixed-point model of the integrator. Depends on ddoi_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module diff_drive_odometry_integrator_test;

   localparam int STEPS = 16;
   localparam int LATENCY = 2 * STEPS + 51;

   typedef struct packed {
      logic [31:0] ref_y;
      logic [31:0] ref_x;
      logic [15:0] heading;
      logic [15:0] speed_right;
      logic [15:0] speed_left;
   } odo_req_type;

   typedef struct packed {
      logic [31:0] err_norm;
      logic [31:0] err_y;
      logic [31:0] err_x;
      logic [31:0] turn_rate;
      logic [31:0] vel_y;
      logic [31:0] vel_x;
      logic [31:0] pos_y;
      logic [31:0] pos_x;
   } odo_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [111:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = ddoi_pkg::CSR_HWR;
   logic [23:0] csr_data = '0;

   always #6 clock = ~clock;

   diff_drive_odometry_integrator #(.CORDIC_STEPS(STEPS)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   longint half_radius, radius_track, step_time;
   longint odo_x, odo_y;
   odo_rsp_type expected_rsp[$];
   int mismatches = 0;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [31:0] turn_atan(int i);
      case (i)
         0:  return 32'h20000000;  1:  return 32'h12E4051E;
         2:  return 32'h09FB385B;  3:  return 32'h051111D4;
         4:  return 32'h028B0D43;  5:  return 32'h0145D7E1;
         6:  return 32'h00A2F61E;  7:  return 32'h00517C55;
         8:  return 32'h0028BE53;  9:  return 32'h00145F2F;
         10: return 32'h000A2F98;  11: return 32'h000517CC;
         12: return 32'h00028BE6;  13: return 32'h000145F3;
         14: return 32'h0000A2FA;  15: return 32'h0000517D;
         default: return 32'h0;
      endcase
   endfunction

   // rotation-mode CORDIC, cos and sin in Q2.30
   task automatic sin_cos(input logic [15:0] angle, output longint c, output longint s);
      logic [31:0] a;
      bit flip;
      longint x, y, z, nx;
      a = {angle, 16'h0};
      flip = 0;
      if (((a + 32'h40000000) >> 31) != 0) begin
         a = a - 32'h80000000;
         flip = 1;
      end
      z = longint'($signed(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(turn_atan(i));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(turn_atan(i));
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic [63:0] int_sqrt(logic [63:0] num);
      logic [63:0] res, b;
      res = 0;
      b = 64'h1 << 62;
      while (b > num) b >>= 2;
      while (b != 0) begin
         if (num >= res + b) begin
            num -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   task automatic predict_odometry(input odo_req_type r, output odo_rsp_type o);
      longint wl, wr, v, w, p, d, travel, c, s, vx, vy, rx, ry;
      logic [63:0] ex, ey, sx2, sy2, nrm;
      logic [15:0] ang;
      wl = longint'($signed(r.speed_left));
      wr = longint'($signed(r.speed_right));
      rx = longint'($signed(r.ref_x));
      ry = longint'($signed(r.ref_y));
      v = (wr + wl) * half_radius >>> 8;
      w = (wr - wl) * radius_track >>> 8;
      p = w * step_time >>> 24;
      d = p * 64'sd341782638 >>> 32;
      ang = r.heading + d[15:0];
      travel = v * step_time >>> 24;
      sin_cos(ang, c, s);
      odo_x = clamp32(odo_x + (travel * c >>> 30));
      odo_y = clamp32(odo_y + (travel * s >>> 30));
      sin_cos(r.heading, c, s);
      vx = v * c >>> 30;
      vy = v * s >>> 30;
      ex = (odo_x >= rx) ? odo_x - rx : rx - odo_x;
      ey = (odo_y >= ry) ? odo_y - ry : ry - odo_y;
      sx2 = ex * ex;
      sy2 = ey * ey;
      if (sx2 > ~sy2) nrm = 64'hFFFFFFFF;
      else nrm = int_sqrt(sx2 + sy2);
      if (nrm > 64'hFFFFFFFF) nrm = 64'hFFFFFFFF;
      o.pos_x = odo_x[31:0];
      o.pos_y = odo_y[31:0];
      o.vel_x = vx[31:0];
      o.vel_y = vy[31:0];
      o.turn_rate = w[31:0];
      o.err_x = ex[31:0];
      o.err_y = ey[31:0];
      o.err_norm = nrm[31:0];
   endtask

   // csr_valid stays high across back-to-back writes; random_phase drops it
   task automatic write_csr(input ddoi_pkg::csr_idx_type idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         ddoi_pkg::CSR_HWR: half_radius = value[15:0];
         ddoi_pkg::CSR_ROT: radius_track = value[15:0];
         default: step_time = value;
      endcase
   endtask

   // burst/gap sender state
   int burst_left = 0;

   task automatic send_request(input odo_req_type r);
      odo_rsp_type o;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_odometry(r, o);
      expected_rsp.push_back(o);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // receiver stall pattern: long ready stretches, then short random stalls
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) rsp_tready <= 1'b0;
      else if (stall_phase[9:8] == 2'd0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0) ||
                         (stall_phase[9:8] == 2'd3 && $urandom_range(0, 40) == 0);
   end

   always @(posedge clock) begin
      odo_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch\n exp %h\n got %h", want, got);
            end
         end
      end
   end

   // directed table: a few rows carry a typed expected response
   typedef struct {
      odo_req_type r;
      bit known;
      odo_rsp_type rsp;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic odo_req_type make_req(logic [15:0] wl, logic [15:0] wr,
         logic [15:0] h, logic [31:0] rx, logic [31:0] ry);
      odo_req_type r;
      r.speed_left = wl;
      r.speed_right = wr;
      r.heading = h;
      r.ref_x = rx;
      r.ref_y = ry;
      return r;
   endfunction

   task automatic add_row(input odo_req_type r);
      directed_row_type d;
      d.r = r;
      d.known = 0;
      d.rsp = '0;
      directed_rows.push_back(d);
   endtask

   task automatic random_phase(input int count, input bit drive_far);
      odo_req_type r;
      csr_valid <= 1'b0;
      for (int i = 0; i < count; i++) begin
         r = make_req($urandom, $urandom, $urandom, $urandom, $urandom);
         if ($urandom_range(0, 3) != 0) begin
            // mostly moderate speeds and nearby references
            r.speed_left = $urandom_range(0, 8191) - 4096;
            r.speed_right = $urandom_range(0, 8191) - 4096;
            r.ref_x = odo_x + $urandom_range(0, 2000000) - 1000000;
            r.ref_y = odo_y + $urandom_range(0, 2000000) - 1000000;
         end
         if (drive_far) begin
            r.speed_left = 16'h7FFF;
            r.speed_right = 16'h7FFF;
         end
         send_request(r);
      end
   endtask

   initial begin
      directed_row_type d;
      odo_rsp_type o;
      half_radius = 4358;
      radius_track = 14289;
      step_time = 83886;
      odo_x = 0;
      odo_y = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // standing still from reset: everything zero
      d.r = '0;
      d.known = 1;
      d.rsp = '0;
      directed_rows.push_back(d);
      // standing still, reference at extremes: errors read straight off
      d.r = make_req(0, 0, 0, 32'h7FFFFFFF, 32'h80000000);
      d.rsp = '0;
      d.rsp.err_x = 32'h7FFFFFFF;
      d.rsp.err_y = 32'h80000000;
      d.rsp.err_norm = 32'hB504F333;
      directed_rows.push_back(d);
      add_row(make_req(16'h0100, 16'h0100, 16'h0000, 0, 0));
      add_row(make_req(16'h0100, 16'h0100, 16'h4000, 0, 0));
      add_row(make_req(16'h0100, 16'h0100, 16'h8000, 0, 0));
      add_row(make_req(16'h0100, 16'h0100, 16'hC000, 0, 0));
      add_row(make_req(16'h8000, 16'h7FFF, 16'h2000, 32'h12345678, 32'hFEDCBA98));
      add_row(make_req(16'h7FFF, 16'h8000, 16'hA000, 32'h80000000, 32'h7FFFFFFF));
      add_row(make_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFFFFFF, 32'h00000001));
      add_row(make_req(16'h8000, 16'h8000, 16'hFFFF, 32'h55555555, 32'hAAAAAAAA));
      add_row(make_req(16'hFFFF, 16'h0001, 16'h6000, 0, 32'hFFFFFFFF));
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].r);
         if (directed_rows[i].known) begin
            void'(expected_rsp.pop_back());
            expected_rsp.push_back(directed_rows[i].rsp);
         end
      end
      drain_responses();

      // extreme registers, then saturate the position with long steps
      write_csr(ddoi_pkg::CSR_HWR, 24'hFFFF);
      write_csr(ddoi_pkg::CSR_ROT, 24'hFFFF);
      write_csr(ddoi_pkg::CSR_TS, 24'hFFFFFF);
      random_phase(150, 1);
      random_phase(100, 0);
      drain_responses();
      // shortest time step and zero gains: position frozen
      write_csr(ddoi_pkg::CSR_TS, 24'd1);
      write_csr(ddoi_pkg::CSR_HWR, 24'h0);
      write_csr(ddoi_pkg::CSR_ROT, 24'h0);
      random_phase(150, 0);
      drain_responses();
      write_csr(ddoi_pkg::CSR_HWR, 24'd4358);
      write_csr(ddoi_pkg::CSR_ROT, 24'd14289);
      write_csr(ddoi_pkg::CSR_TS, 24'd83886);
      random_phase(450, 0);
      drain_responses();
      write_csr(ddoi_pkg::CSR_HWR, $urandom_range(0, 65535));
      write_csr(ddoi_pkg::CSR_ROT, $urandom_range(0, 65535));
      write_csr(ddoi_pkg::CSR_TS, $urandom_range(1, 24'hFFFFFF));
      random_phase(490, 0);
      drain_responses();

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/ddoi_pkg.sv
rtl/ddoi_ctrl.sv
rtl/ddoi_datapath.sv
rtl/diff_drive_odometry_integrator.sv
rtl/ddoi_checker.sv
tb/diff_drive_odometry_integrator_test.sv
